### rtl/core/odv_pkg.sv
// Package for the body frame odometry velocity block.
// Holds widths, the sequencer state type and small helpers; depends on nothing.
package odv_pkg;

    localparam int PosWidth      = 32;
    localparam int QuatFracBits  = 14;
    localparam int DiffWidth     = PosWidth + 1;
    localparam int ProdWidth     = DiffWidth + 30;
    localparam int NumWidth      = ProdWidth + 1;
    localparam logic [29:0] NsPerSec = 30'd1000000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME_LO,
        ST_TIME_HI,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_DIV_END,
        ST_QMUL,
        ST_ROT,
        ST_ROT_END,
        ST_OUT
    } t_state;

    function automatic logic [30:0] abs_sat31(input logic signed [31:0] c);
        logic [31:0] m;
        m = c[31] ? 32'(-c) : 32'(c);
        return (m > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        else if (x < -64'sd2147483648) return 32'h8000_0000;
        else return x[31:0];
    endfunction

endpackage

### rtl/core/odom_velocity_body_frame_top.sv
// Top level of the body frame odometry velocity block.
// Depends on odv_pkg for widths, the state type and helpers.
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   stamp, position, quaternion, covariance
// out      output     o_out_valid / i_out_ready velocities and variances
//
// For each sample the time is first built in nanoseconds on the shared 33x33
// multiplier. Each axis then runs the position step, its scaling by 10^9, the
// rounding offset, 64 restoring divider steps and the saturation. The quaternion
// products and the rotation entries are formed next, then the three rotation sums.
// The first sample after reset only loads the stored state and gives no result.
// Reset is synchronous and clears the control state. The input is not ready while a
// sample is being worked on or while a result waits in the output register.
module odom_velocity_body_frame_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_stamp_sec,
    input  logic [29:0]        i_stamp_nsec,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [31:0] i_cov_xx,
    input  logic signed [31:0] i_cov_yy,
    input  logic signed [31:0] i_cov_zz,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_vel_fwd,
    output logic signed [31:0] o_vel_lat,
    output logic signed [31:0] o_vel_vert,
    output logic [30:0]        o_var_x,
    output logic [30:0]        o_var_y,
    output logic [30:0]        o_var_z
);

    localparam int DW = odv_pkg::DiffWidth;
    localparam int NW = odv_pkg::NumWidth;

    odv_pkg::t_state r_state, n_state;
    logic            r_have_prev;
    logic [63:0]     r_prev_time, r_time;
    logic signed [31:0] r_prev_pos [3];
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_q [4];
    logic signed [31:0] r_cov [3];
    logic [1:0]      r_axis;
    logic [5:0]      r_step;
    logic [3:0]      r_idx;
    logic [63:0]     r_dmag;
    logic            r_dneg;
    logic [31:0]     r_amag;
    logic            r_dsign;
    logic [63:0]     r_plo;
    logic [NW-1:0]   r_num;
    logic [64:0]     r_rem;
    logic [32:0]     r_quo;
    logic            r_over;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_qp [9];
    logic signed [17:0] r_rot [9];
    logic signed [63:0] r_acc;
    logic signed [31:0] r_res [3];
    logic            r_out_valid;

    // Shared signed 33x33 multiplier with operand selection.
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    assign w_mp = w_ma * w_mb;

    logic [63:0] w_t_dmag;
    logic        w_t_neg;
    logic signed [DW-1:0] w_diff;
    logic [64:0] w_rem_sh;
    logic        w_ge;
    logic [63:0] w_q;
    logic signed [31:0] w_raw [9];
    logic signed [31:0] w_one;

    assign w_one = 32'sd1 <<< (2 * odv_pkg::QuatFracBits);

    // Rotation matrix raw entries from quaternion products:
    // 0 xx,1 yy,2 zz,3 xy,4 xz,5 yz,6 xw,7 yw,8 zw
    always_comb begin
        w_raw[0] = w_one - 2 * (r_qp[1] + r_qp[2]);
        w_raw[1] = 2 * (r_qp[3] - r_qp[8]);
        w_raw[2] = 2 * (r_qp[4] + r_qp[7]);
        w_raw[3] = 2 * (r_qp[3] + r_qp[8]);
        w_raw[4] = w_one - 2 * (r_qp[0] + r_qp[2]);
        w_raw[5] = 2 * (r_qp[5] - r_qp[6]);
        w_raw[6] = 2 * (r_qp[4] - r_qp[7]);
        w_raw[7] = 2 * (r_qp[5] + r_qp[6]);
        w_raw[8] = w_one - 2 * (r_qp[0] + r_qp[1]);
    end

    assign w_t_neg  = r_time < r_prev_time;
    assign w_t_dmag = w_t_neg ? r_prev_time - r_time : r_time - r_prev_time;
    assign w_diff   = DW'(r_pos[r_axis]) - DW'(r_prev_pos[r_axis]);
    assign w_rem_sh = {r_rem[63:0], r_num[NW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dmag};
    assign w_q      = 64'({r_quo, w_ge});

    // Multiplier operands by state.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            odv_pkg::ST_TIME_LO: begin
                w_ma = {1'b0, r_time[31:0]};
                w_mb = 33'(odv_pkg::NsPerSec);
            end
            odv_pkg::ST_MUL_LO: begin
                w_ma = {1'b0, r_amag};
                w_mb = 33'(odv_pkg::NsPerSec);
            end
            odv_pkg::ST_QMUL: begin
                unique case (r_idx)
                    4'd0: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[0]); end
                    4'd1: begin w_ma = 33'(r_q[1]); w_mb = 33'(r_q[1]); end
                    4'd2: begin w_ma = 33'(r_q[2]); w_mb = 33'(r_q[2]); end
                    4'd3: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[1]); end
                    4'd4: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[2]); end
                    4'd5: begin w_ma = 33'(r_q[1]); w_mb = 33'(r_q[2]); end
                    4'd6: begin w_ma = 33'(r_q[0]); w_mb = 33'(r_q[3]); end
                    4'd7: begin w_ma = 33'(r_q[1]); w_mb = 33'(r_q[3]); end
                    default: begin w_ma = 33'(r_q[2]); w_mb = 33'(r_q[3]); end
                endcase
            end
            odv_pkg::ST_ROT: begin
                // column r_axis, row r_idx: r[row][col] * v[row]
                w_ma = 33'(r_rot[r_idx[1:0] * 3 + r_axis]);
                w_mb = 33'(r_vel[r_idx[1:0]]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            odv_pkg::ST_IDLE:
                if (i_in_valid && o_in_ready) n_state = odv_pkg::ST_TIME_LO;
            odv_pkg::ST_TIME_LO: n_state = odv_pkg::ST_TIME_HI;
            odv_pkg::ST_TIME_HI:
                n_state = r_have_prev ? odv_pkg::ST_DIFF : odv_pkg::ST_IDLE;
            odv_pkg::ST_DIFF:   n_state = odv_pkg::ST_MUL_LO;
            odv_pkg::ST_MUL_LO: n_state = odv_pkg::ST_MUL_HI;
            odv_pkg::ST_MUL_HI: n_state = odv_pkg::ST_DIV;
            odv_pkg::ST_DIV:
                if (r_step == 6'd0) n_state = odv_pkg::ST_DIV_END;
            odv_pkg::ST_DIV_END:
                n_state = (r_axis == 2'd2) ? odv_pkg::ST_QMUL : odv_pkg::ST_DIFF;
            odv_pkg::ST_QMUL:
                if (r_idx == 4'd9) n_state = odv_pkg::ST_ROT;
            odv_pkg::ST_ROT:
                if (r_idx == 4'd2) n_state = odv_pkg::ST_ROT_END;
            odv_pkg::ST_ROT_END:
                n_state = (r_axis == 2'd2) ? odv_pkg::ST_OUT : odv_pkg::ST_ROT;
            odv_pkg::ST_OUT: n_state = odv_pkg::ST_IDLE;
            default: n_state = odv_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready = (r_state == odv_pkg::ST_IDLE) && !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= odv_pkg::ST_IDLE;
            r_have_prev <= 1'b0;
            r_prev_time <= '0;
            r_prev_pos  <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == odv_pkg::ST_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (r_state == odv_pkg::ST_TIME_HI) begin
                // The first sample stores its time and position once time is
                // complete; later samples update them after the last rotation sum.
                r_have_prev <= 1'b1;
                if (!r_have_prev) begin
                    r_prev_time <= r_time + r_plo;
                    r_prev_pos  <= r_pos;
                end
            end else if (r_state == odv_pkg::ST_ROT_END && r_axis == 2'd2) begin
                r_prev_time <= r_time;
                r_prev_pos  <= r_pos;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            odv_pkg::ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    r_time   <= {32'd0, i_stamp_sec};
                    r_plo    <= {34'd0, i_stamp_nsec};
                    r_pos[0] <= i_pos_x;
                    r_pos[1] <= i_pos_y;
                    r_pos[2] <= i_pos_z;
                    r_q[0]   <= i_quat_x;
                    r_q[1]   <= i_quat_y;
                    r_q[2]   <= i_quat_z;
                    r_q[3]   <= i_quat_w;
                    r_cov[0] <= i_cov_xx;
                    r_cov[1] <= i_cov_yy;
                    r_cov[2] <= i_cov_zz;
                end
            end
            odv_pkg::ST_TIME_LO: begin
                // Seconds times 10^9 fits in 62 bits; r_plo holds nanoseconds.
                r_time <= w_mp[63:0];
            end
            odv_pkg::ST_TIME_HI: begin
                r_time <= r_time + r_plo;
                r_axis <= 2'd0;
            end
            odv_pkg::ST_DIFF: begin
                if (r_axis == 2'd0) begin
                    r_dneg <= w_t_neg;
                    r_dmag <= w_t_dmag;
                end
                r_dsign <= w_diff[DW-1];
                r_amag  <= 32'(w_diff[DW-1] ? -w_diff : w_diff);
            end
            odv_pkg::ST_MUL_LO: begin
                r_plo <= w_mp[63:0];
            end
            odv_pkg::ST_MUL_HI: begin
                // Magnitude below 2^32, so one product suffices; add half divisor.
                // The whole numerator fits in 64 bits, so 64 divider steps suffice.
                r_num  <= NW'(r_plo) + NW'(r_dmag >> 1);
                r_rem  <= '0;
                r_quo  <= '0;
                r_over <= 1'b0;
                r_step <= 6'd63;
            end
            odv_pkg::ST_DIV: begin
                r_num <= {r_num[NW-2:0], 1'b0};
                r_rem <= w_ge ? w_rem_sh - {1'b0, r_dmag} : w_rem_sh;
                if (!r_over) begin
                    r_quo <= w_q[32:0];
                    if (w_q > 64'h1_0000_0000) r_over <= 1'b1;
                end
                r_step <= r_step - 6'd1;
            end
            odv_pkg::ST_DIV_END: begin
                if (r_dmag == 64'd0) begin
                    r_vel[r_axis] <= '0;
                end else if (r_dsign != r_dneg) begin
                    r_vel[r_axis] <= (r_over || r_quo > 33'h0_8000_0000)
                                     ? 32'sh8000_0000 : 32'(-r_quo);
                end else begin
                    r_vel[r_axis] <= (r_over || r_quo > 33'h0_7FFF_FFFF)
                                     ? 32'sh7FFF_FFFF : r_quo[31:0];
                end
                r_axis <= r_axis + 2'd1;
                r_idx  <= 4'd0;
            end
            odv_pkg::ST_QMUL: begin
                // Nine products are stored first, then the raw entries see every
                // product and the rotation entries are loaded.
                if (r_idx != 4'd9) r_qp[r_idx] <= w_mp[31:0];
                if (r_idx == 4'd9) begin
                    r_idx  <= 4'd0;
                    r_axis <= 2'd0;
                    r_acc  <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            odv_pkg::ST_ROT: begin
                r_acc <= r_acc + 64'(w_mp);
                r_idx <= r_idx + 4'd1;
            end
            odv_pkg::ST_ROT_END: begin
                r_res[r_axis] <= odv_pkg::sat32(
                    ((r_axis == 2'd0 ? r_acc : -r_acc)
                     + (64'sd1 <<< (odv_pkg::QuatFracBits - 1)))
                    >>> odv_pkg::QuatFracBits);
                r_axis <= r_axis + 2'd1;
                r_idx  <= 4'd0;
                r_acc  <= '0;
            end
            default: begin
            end
        endcase
        if (r_state == odv_pkg::ST_QMUL && r_idx == 4'd9) begin
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= 18'((w_raw[k] + (32'sd1 <<< (odv_pkg::QuatFracBits - 1)))
                                >>> odv_pkg::QuatFracBits);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vel_fwd   = r_res[0];
    assign o_vel_lat   = r_res[1];
    assign o_vel_vert  = r_res[2];
    assign o_var_x     = odv_pkg::abs_sat31(r_cov[0]);
    assign o_var_y     = odv_pkg::abs_sat31(r_cov[1]);
    assign o_var_z     = odv_pkg::abs_sat31(r_cov[2]);

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == odv_pkg::ST_IDLE)
        else $error("input ready outside idle");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == odv_pkg::ST_OUT)
        else $error("result appeared without sequencer");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_res[0]))
        else $error("result dropped while stalled");
    a_have_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == odv_pkg::ST_DIFF |-> r_have_prev)
        else $error("difference without previous sample");
`endif

endmodule
